FILE: rtl/ciou_pkg.sv
// Shared types and constants for the class-aware IoU box suppression block.
package ciou_pkg;

  // Field widths
  localparam int unsigned CoordW = 10;
  localparam int unsigned LabelW = 8;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ThrW   = 9;

  // Kept-box store geometry
  localparam int unsigned MaxKept = 64;
  localparam int unsigned KeptAw  = $clog2(MaxKept);
  localparam int unsigned CountW  = $clog2(MaxKept + 1);

  // Overlap arithmetic widths
  localparam int unsigned AreaW = 2 * CoordW;
  localparam int unsigned UniW  = AreaW + 1;
  localparam int unsigned ProdW = ThrW + UniW;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(115);

  // Input beat
  typedef struct packed {
    logic [CoordW-1:0] box_x;
    logic [CoordW-1:0] box_y;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [LabelW-1:0] class_label;
    logic              frame_last;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic            kept;
    logic [IdxW-1:0] candidate_index;
    logic            store_overflow;
    logic            result_last;
  } out_beat_t;

  // Candidate as queued between front and back
  typedef struct packed {
    in_beat_t        beat;
    logic [IdxW-1:0] index;
  } cand_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    cand_t cand;
  } head_t;

  // One entry of the kept-box store
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    logic [LabelW-1:0] label;
  } box_t;

endpackage

FILE: rtl/class_aware_iou_box_suppression.sv
// Class-aware greedy IoU suppression: boxes arrive in descending score order, one
// result beat per input beat. Each box is tested against every box kept so far in
// the frame with the same label, one stored box per cycle through a four-stage
// compare pipeline fed from the 64-entry kept-box store, whose single read port
// sets that rate. A two-entry queue lets input beats arrive while a scan runs, and
// the result register holds a finished beat while the next box is already queued.
// Boxes kept once the store is full are reported kept with store_overflow set. The
// user must write the threshold register (Q1.8, reset 115) only while the block is
// idle; the block itself does not enforce this.
module class_aware_iou_box_suppression (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ciou_pkg::in_beat_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ciou_pkg::out_beat_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [ciou_pkg::ThrW-1:0] cfg_wdata_i
);
  import ciou_pkg::*;

  logic [ThrW-1:0] thr_q;
  head_t           head;
  logic            pop;

  // Overlap threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  ciou_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .head_o    (head),
    .pop_i     (pop)
  );

  ciou_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .thr_i      (thr_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: rtl/ciou_front.sv
// Front end: accepts input beats, numbers them within the frame, queues them.
module ciou_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ciou_pkg::in_beat_t in_data_i,
  output ciou_pkg::head_t   head_o,
  input  logic              pop_i
);
  import ciou_pkg::*;

  localparam int unsigned Depth = 2;

  cand_t             fifo_q [Depth];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              push;
  logic              pop;

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cand  = fifo_q[rd_ptr_q];

  // Pointer, fill and candidate numbering
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
    idx_d    = idx_q;
    if (push) begin
      idx_d = in_data_i.frame_last ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{beat: in_data_i, index: idx_q};
    end
  end

endmodule

FILE: rtl/ciou_back.sv
// Back end: scans the kept-box store for each candidate and issues the result beat.
module ciou_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ciou_pkg::head_t            head_i,
  output logic                       pop_o,
  input  logic [ciou_pkg::ThrW-1:0]  thr_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ciou_pkg::out_beat_t        out_data_o
);
  import ciou_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]         state_q, state_d;

  // Candidate under test
  box_t               cand_q;
  logic [IdxW-1:0]    cidx_q;
  logic               clast_q;
  logic [AreaW-1:0]   area_a_q;

  // Scan control
  logic [CountW-1:0]  issue_q, issue_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               supp_q, supp_d;
  logic               issue;

  // Kept-box store
  box_t               mem [MaxKept];
  box_t               rd_q;
  logic               pv_q;

  // Compare pipeline
  logic               hit1_q, hit2_q, hit3_q;
  logic [CoordW-1:0]  sx_q, sy_q, bw_q, bh_q;
  logic [AreaW-1:0]   inter2_q, areab_q;
  logic [AreaW-1:0]   inter3_q;
  logic [UniW-1:0]    uni3_q;

  logic [CoordW:0]    ae_x, be_x, ae_y, be_y, hi_x, hi_y;
  logic [CoordW-1:0]  lo_x, lo_y, span_x, span_y;
  logic [UniW-1:0]    uni_sum, uni_clamp;
  logic [ProdW-1:0]   lhs, rhs;
  logic               over;

  // Result
  out_beat_t          out_q;
  logic               out_valid_q;
  logic               fire;
  logic               keep, store;

  assign pop_o = (state_q == StIdle) && head_i.valid;
  assign issue = (state_q == StScan) && (issue_q < count_q);
  assign fire  = (state_q == StDone) && (!out_valid_q || !out_stall_i);
  assign keep  = !supp_q;
  assign store = keep && (count_q < CountW'(MaxKept));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stage 1: per-axis overlap spans
  always_comb begin
    ae_x   = {1'b0, cand_q.x} + {1'b0, cand_q.w};
    be_x   = {1'b0, rd_q.x} + {1'b0, rd_q.w};
    ae_y   = {1'b0, cand_q.y} + {1'b0, cand_q.h};
    be_y   = {1'b0, rd_q.y} + {1'b0, rd_q.h};
    lo_x   = (cand_q.x > rd_q.x) ? cand_q.x : rd_q.x;
    lo_y   = (cand_q.y > rd_q.y) ? cand_q.y : rd_q.y;
    hi_x   = (ae_x < be_x) ? ae_x : be_x;
    hi_y   = (ae_y < be_y) ? ae_y : be_y;
    span_x = (hi_x > {1'b0, lo_x}) ? CoordW'(hi_x - {1'b0, lo_x}) : '0;
    span_y = (hi_y > {1'b0, lo_y}) ? CoordW'(hi_y - {1'b0, lo_y}) : '0;
  end

  // Stage 3: union clamped to at least one
  always_comb begin
    uni_sum   = UniW'(area_a_q) + UniW'(areab_q) - UniW'(inter2_q);
    uni_clamp = (uni_sum == '0) ? UniW'(1) : uni_sum;
  end

  // Stage 4: inter*256 > thr*union
  assign lhs  = ProdW'({inter3_q, 8'b0});
  assign rhs  = ProdW'(thr_i) * ProdW'(uni3_q);
  assign over = hit3_q && (lhs > rhs);

  // Sequencer
  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    count_d = count_q;
    supp_d  = supp_q || over;
    unique case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          state_d = StScan;
          issue_d = '0;
          supp_d  = 1'b0;
        end
      end
      StScan: begin
        if (issue) begin
          issue_d = issue_q + CountW'(1);
        end else if (!pv_q && !hit1_q && !hit2_q && !hit3_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (fire) begin
          state_d = StIdle;
          count_d = clast_q ? '0 : count_q + CountW'(store);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issue_q     <= '0;
      count_q     <= '0;
      supp_q      <= 1'b0;
      pv_q        <= 1'b0;
      hit1_q      <= 1'b0;
      hit2_q      <= 1'b0;
      hit3_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      count_q <= count_d;
      supp_q  <= supp_d;
      pv_q    <= issue;
      hit1_q  <= pv_q && (rd_q.label == cand_q.label);
      hit2_q  <= hit1_q;
      hit3_q  <= hit2_q;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store read and write
  always_ff @(posedge clk_i) begin
    rd_q <= mem[issue_q[KeptAw-1:0]];
    if (fire && store) begin
      mem[count_q[KeptAw-1:0]] <= cand_q;
    end
  end

  // Payload registers: candidate, compare pipeline, result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cand_q.x     <= head_i.cand.beat.box_x;
      cand_q.y     <= head_i.cand.beat.box_y;
      cand_q.w     <= head_i.cand.beat.box_width;
      cand_q.h     <= head_i.cand.beat.box_height;
      cand_q.label <= head_i.cand.beat.class_label;
      cidx_q       <= head_i.cand.index;
      clast_q      <= head_i.cand.beat.frame_last;
      area_a_q     <= AreaW'(head_i.cand.beat.box_width) *
                      AreaW'(head_i.cand.beat.box_height);
    end
    sx_q     <= span_x;
    sy_q     <= span_y;
    bw_q     <= rd_q.w;
    bh_q     <= rd_q.h;
    inter2_q <= AreaW'(sx_q) * AreaW'(sy_q);
    areab_q  <= AreaW'(bw_q) * AreaW'(bh_q);
    inter3_q <= inter2_q;
    uni3_q   <= uni_clamp;
    if (fire) begin
      out_q.kept            <= keep;
      out_q.candidate_index <= cidx_q;
      out_q.store_overflow  <= keep && !store;
      out_q.result_last     <= clast_q;
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench for class_aware_iou_box_suppression: random and directed boxes vs an IoU predictor.

// Tracks kept boxes per frame and predicts the verdict for each accepted box
class suppression_scoreboard;
  ciou_pkg::box_t            kept_store[ciou_pkg::MaxKept];
  int unsigned               kept_count;
  logic [ciou_pkg::IdxW-1:0] next_index;
  logic [ciou_pkg::ThrW-1:0] threshold;
  ciou_pkg::out_beat_t       verdicts_due[$];
  int unsigned               errors;

  function new();
    kept_count = 0;
    next_index = '0;
    threshold  = ciou_pkg::ThrReset;
    errors     = 0;
  endfunction

  static function int unsigned span_overlap(int unsigned a0, int unsigned alen,
                                            int unsigned b0, int unsigned blen);
    int unsigned lo;
    int unsigned hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // inter * 256 > thr * union, union clamped to at least one
  function bit overlaps_too_much(ciou_pkg::box_t a, ciou_pkg::box_t b);
    longint unsigned ox, oy, inter, area_a, area_b, uni;
    ox     = 64'(span_overlap(32'(a.x), 32'(a.w), 32'(b.x), 32'(b.w)));
    oy     = 64'(span_overlap(32'(a.y), 32'(a.h), 32'(b.y), 32'(b.h)));
    inter  = ox * oy;
    area_a = 64'(a.w) * 64'(a.h);
    area_b = 64'(b.w) * 64'(b.h);
    uni    = area_a + area_b - inter;
    if (uni < 1) begin
      uni = 1;
    end
    return (inter * 256) > (64'(threshold) * uni);
  endfunction

  // Accepted input beat: work out its verdict and update the frame state
  function void note_input(ciou_pkg::in_beat_t beat);
    ciou_pkg::box_t      cand;
    ciou_pkg::out_beat_t verdict;
    bit                  keep;
    cand.x     = beat.box_x;
    cand.y     = beat.box_y;
    cand.w     = beat.box_width;
    cand.h     = beat.box_height;
    cand.label = beat.class_label;
    keep       = 1'b1;
    for (int i = 0; i < kept_count; i++) begin
      if (kept_store[i].label == cand.label && overlaps_too_much(cand, kept_store[i])) begin
        keep = 1'b0;
      end
    end
    verdict.kept           = keep;
    verdict.store_overflow = 1'b0;
    if (keep) begin
      if (kept_count < ciou_pkg::MaxKept) begin
        kept_store[kept_count] = cand;
        kept_count++;
      end else begin
        verdict.store_overflow = 1'b1;
      end
    end
    verdict.candidate_index = next_index;
    verdict.result_last     = beat.frame_last;
    verdicts_due = {verdicts_due, verdict};
    next_index++;
    if (beat.frame_last) begin
      kept_count = 0;
      next_index = '0;
    end
  endfunction

  function int unsigned pending();
    return verdicts_due.size();
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Accepted result beat: compare with the oldest predicted verdict
  task check(ciou_pkg::out_beat_t got);
    ciou_pkg::out_beat_t want;
    if (verdicts_due.size() == 0) begin
      report($sformatf("result beat index %0d with nothing pending", got.candidate_index));
      return;
    end
    want = verdicts_due.pop_front();
    if (got.kept !== want.kept) begin
      report($sformatf("index %0d kept got %0b want %0b",
                       want.candidate_index, got.kept, want.kept));
    end
    if (got.candidate_index !== want.candidate_index) begin
      report($sformatf("candidate_index got %0d want %0d",
                       got.candidate_index, want.candidate_index));
    end
    if (got.store_overflow !== want.store_overflow) begin
      report($sformatf("index %0d store_overflow got %0b want %0b",
                       want.candidate_index, got.store_overflow, want.store_overflow));
    end
    if (got.result_last !== want.result_last) begin
      report($sformatf("index %0d result_last got %0b want %0b",
                       want.candidate_index, got.result_last, want.result_last));
    end
  endtask
endclass

module tb;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 600;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  ciou_pkg::in_beat_t        in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  ciou_pkg::out_beat_t       out_data;
  logic                      cfg_we    = 1'b0;
  logic [ciou_pkg::ThrW-1:0] cfg_wdata = '0;

  suppression_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  bit          sender_steady = 1'b0;
  bit          hold_request  = 1'b0;

  class_aware_iou_box_suppression uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check(out_data);
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold-off
  initial begin
    stall_mode_e stall_mode;
    int unsigned mode_left;
    int unsigned tick;
    stall_mode = StallNone;
    mode_left  = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
        out_stall    = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        case (stall_mode)
          StallNone:  out_stall = 1'b0;
          StallLight: out_stall = ($urandom_range(0, 7) == 0);
          StallHeavy: out_stall = ($urandom_range(0, 1) == 1);
          default:    out_stall = ((tick % 5) < 2);
        endcase
      end
    end
  end

  function automatic ciou_pkg::in_beat_t mk_box(int unsigned x, int unsigned y,
                                                int unsigned w, int unsigned h,
                                                int unsigned label, bit last);
    ciou_pkg::in_beat_t b;
    b.box_x       = x[9:0];
    b.box_y       = y[9:0];
    b.box_width   = w[9:0];
    b.box_height  = h[9:0];
    b.class_label = label[7:0];
    b.frame_last  = last;
    return b;
  endfunction

  // Random offset around v, kept inside the coordinate range
  function automatic int unsigned nudge(int unsigned v, int unsigned span);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (t < 0) begin
      t = 0;
    end else if (t > 1023) begin
      t = 1023;
    end
    return t;
  endfunction

  // Offer one beat; bursts of random length separated by random gaps
  task automatic push_box(input ciou_pkg::in_beat_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = sender_steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = b;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    sb.note_input(b);
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Threshold write, only once the block has gone idle
  task automatic write_threshold(input logic [ciou_pkg::ThrW-1:0] value);
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    sb.threshold = value;
  endtask

  // Frames of clustered boxes, with some noise beats and broken frames mixed in
  task automatic run_random_frames(input int unsigned n_items);
    int unsigned sent, frame_len, n_groups, g, pick, lbl_base;
    int unsigned cx[4], cy[4], cw[4], ch[4];
    ciou_pkg::in_beat_t b;
    sent = 0;
    while (sent < n_items) begin
      frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 90) : $urandom_range(2, 30);
      n_groups  = $urandom_range(1, 4);
      lbl_base  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
      for (int c = 0; c < 4; c++) begin
        cx[c] = $urandom_range(0, 1023);
        cy[c] = $urandom_range(0, 1023);
        cw[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(600, 1023) : $urandom_range(1, 200);
        ch[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(600, 1023) : $urandom_range(1, 200);
      end
      for (int k = 0; k < frame_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          b = mk_box($urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 255), ($urandom_range(0, 15) == 0));
        end else begin
          g = $urandom_range(0, n_groups - 1);
          b = mk_box(nudge(cx[g], 24), nudge(cy[g], 24), nudge(cw[g], 12), nudge(ch[g], 12),
                     lbl_base + $urandom_range(0, 2), (k == frame_len - 1));
          // empty boxes now and then
          if (pick < 12) begin
            b.box_width = '0;
          end else if (pick < 16) begin
            b.box_height = '0;
          end
        end
        push_box(b);
      end
      sent += frame_len;
    end
  endtask

  // One frame of small boxes on a 32-pixel grid, so the store fills up;
  // some beats are jittered copies of the previous box
  task automatic grid_frame(input int unsigned n, input int unsigned copy_pct);
    int unsigned slot;
    ciou_pkg::in_beat_t b, prev;
    prev = '0;
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 99) < copy_pct) begin
        b = mk_box(nudge(32'(prev.box_x), 3), nudge(32'(prev.box_y), 3),
                   nudge(32'(prev.box_width), 2), nudge(32'(prev.box_height), 2),
                   32'(prev.class_label), 1'b0);
      end else begin
        slot = k % 1024;
        b = mk_box((slot % 32) * 32 + $urandom_range(0, 15),
                   (slot / 32) * 32 + $urandom_range(0, 15),
                   $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 1), 1'b0);
      end
      b.frame_last = (k == n - 1);
      push_box(b);
      prev = b;
    end
  endtask

  // Main sequence
  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty boxes, duplicates, labels, partial overlaps, edges, frame ends
    write_threshold(9'd128);
    push_box(mk_box(0, 0, 0, 0, 0, 1'b0));
    push_box(mk_box(0, 0, 0, 0, 0, 1'b0));
    push_box(mk_box(10, 10, 100, 100, 1, 1'b0));
    push_box(mk_box(10, 10, 100, 100, 1, 1'b0));
    push_box(mk_box(10, 10, 100, 100, 2, 1'b0));
    push_box(mk_box(60, 10, 100, 100, 1, 1'b0));
    push_box(mk_box(20, 20, 100, 100, 1, 1'b0));
    push_box(mk_box(110, 10, 100, 100, 1, 1'b0));
    push_box(mk_box(1023, 1023, 1023, 1023, 255, 1'b0));
    push_box(mk_box(1000, 1000, 1023, 1023, 255, 1'b0));
    push_box(mk_box(0, 0, 1023, 1023, 255, 1'b0));
    push_box(mk_box(512, 512, 0, 1023, 255, 1'b0));
    push_box(mk_box(0, 1023, 1023, 0, 170, 1'b0));
    push_box(mk_box(1023, 0, 0, 0, 85, 1'b1));
    push_box(mk_box(10, 10, 100, 100, 1, 1'b0));
    push_box(mk_box(10, 10, 100, 100, 1, 1'b1));

    write_threshold(9'd115);
    run_random_frames(340);

    // Zero threshold: any overlap suppresses; also a frame that overflows the store
    write_threshold(9'd0);
    grid_frame(70, 0);
    run_random_frames(40);

    // Full-scale and above: nothing gets suppressed
    write_threshold(9'd256);
    run_random_frames(50);
    write_threshold(9'd511);
    run_random_frames(40);

    // Back-pressure: receiver holds off while the sender keeps offering
    write_threshold(9'($urandom_range(1, 255)));
    sender_steady = 1'b1;
    @(posedge clk);
    hold_request = 1'b1;
    run_random_frames(80);
    sender_steady = 1'b0;

    // Long frame: the store stays full while jittered copies keep arriving
    write_threshold(9'd115);
    grid_frame(200, 40);

    @(negedge clk);
    in_valid = 1'b0;
    drain_results();
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: class_aware_iou_box_suppression.f
rtl/ciou_pkg.sv
rtl/ciou_front.sv
rtl/ciou_back.sv
rtl/class_aware_iou_box_suppression.sv
sim/tb.sv
